[hdl/tfz_pkg.sv]
// Shared types and constants for the triangular membership fuzzifier.
`default_nettype none

package tfz_pkg;

  localparam int FRAC_W  = 16;
  localparam int SHARE_W = 17;
  localparam int PCT_W   = 23;
  localparam int CFG_W   = 4;
  localparam int CAT_W   = 3;
  localparam int MEMB_W  = 17;

  localparam logic [6:0]         PERCENT = 7'd100;
  localparam logic [SHARE_W-1:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic                    req_type;
    logic [CAT_W-1:0]        cat_index;
    logic signed [15:0]      low_point;
    logic signed [15:0]      mid_point;
    logic signed [15:0]      high_point;
    logic signed [15:0]      sample;
    logic [15:0]             rand_word;
  } req_t;

  typedef struct packed {
    logic [CAT_W-1:0]  category;
    logic [MEMB_W-1:0] membership;
    logic              chosen;
    logic              out_of_range;
    logic              last;
  } res_t;

  typedef struct packed {
    logic signed [15:0] low_point;
    logic signed [15:0] mid_point;
    logic signed [15:0] high_point;
  } bp_t;

  typedef enum logic [1:0] {
    RAMP_ZERO,
    RAMP_PEAK,
    RAMP_RISE,
    RAMP_FALL
  } ramp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P1_RD,
    ST_P1_EVAL,
    ST_P1_DIV,
    ST_P1_ACC,
    ST_CHECK,
    ST_MOD,
    ST_P2_RD,
    ST_P2_EVAL,
    ST_P2_DIV,
    ST_EMIT,
    ST_ZERO
  } state_t;

endpackage

`default_nettype wire

[hdl/tfz_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tfz_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/tfz_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module tfz_div #(
  parameter int DW = 26
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DW-1:0]              rem_init,
  input  logic [tfz_pkg::FRAC_W-1:0] num_bits,
  input  logic [DW-1:0]              den,
  output logic                       done,
  output logic [tfz_pkg::FRAC_W-1:0] quo,
  output logic [DW-1:0]              rem
);

  import tfz_pkg::*;

  localparam int SW = $clog2(FRAC_W + 1);

  logic              running;
  logic [SW-1:0]     steps;
  logic [FRAC_W-1:0] bits;
  logic [DW-1:0]     den_r;
  logic [DW:0]       trial;
  logic              take;

  assign trial = {rem, bits[FRAC_W-1]};
  assign take  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= SW'(FRAC_W);
      end else if (running) begin
        if (steps == SW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        steps <= steps - SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      bits  <= num_bits;
      den_r <= den;
      quo   <= '0;
    end else if (running) begin
      rem  <= take ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      bits <= {bits[FRAC_W-2:0], 1'b0};
      quo  <= {quo[FRAC_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

[hdl/triangular_fuzzifier.sv]
// Top level: triangular membership fuzzifier with weighted category pick.
// Load transaction: busy stays low. Fuzzify transaction: busy from accept until the last result;
// the shared 16-step divider serves the share, modulo and normalize divisions in turn.
// One transaction at a time; results come one per strobe and cannot be stalled.
// Reset clears the controller and the category count; breakpoints are undefined until loaded.
`default_nettype none

module triangular_fuzzifier #(
  parameter int MAX_CATEGORIES = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  tfz_pkg::req_t             req,
  output logic                      result_valid,
  output tfz_pkg::res_t             result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tfz_pkg::CFG_W-1:0] cfg_data
);

  import tfz_pkg::*;

  localparam int AW = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
  localparam int CW = $clog2(MAX_CATEGORIES + 1);
  localparam int TW = PCT_W + $clog2(MAX_CATEGORIES);
  localparam int WW = TW - FRAC_W;

  state_t state, state_next;

  logic [CFG_W-1:0]    num_categories;
  logic [CW-1:0]       count_sat;
  logic [CW-1:0]       count_r;
  logic [AW-1:0]       idx;
  logic signed [15:0]  sample_r;
  logic [15:0]         rand_r;
  logic [SHARE_W-1:0]  share;
  logic [TW-1:0]       total;
  logic [TW-1:0]       limit;
  logic [TW-1:0]       run;
  logic                found;
  logic                chosen_r;
  logic [MEMB_W-1:0]   memb;

  logic accept_load, accept_fz, load_ok, last_idx;

  logic                bp_we, bp_re;
  logic [$bits(bp_t)-1:0] bp_rdata;
  bp_t                 bp_wr, bp;
  logic                pct_we, pct_re;
  logic [PCT_W-1:0]    pct_val, pct_rdata;

  logic                div_start, div_done;
  logic [TW-1:0]       div_init, div_den, div_rem;
  logic [FRAC_W-1:0]   div_bits, div_quo;

  ramp_t               ramp;
  logic signed [16:0]  xs, lo, mi, hi;
  logic signed [16:0]  d_xl, d_ml, d_hx, d_hm;
  logic [WW-1:0]       whole;
  logic [TW-1:0]       run_sum;
  logic                hit;

  assign accept_load = start && !busy && !req.req_type;
  assign accept_fz   = start && !busy && req.req_type;
  assign load_ok     = (int'(req.cat_index) < MAX_CATEGORIES);
  assign last_idx    = ((CW'(idx) + CW'(1)) == count_r);

  always_comb begin
    if (int'(num_categories) > MAX_CATEGORIES) begin
      count_sat = CW'(MAX_CATEGORIES);
    end else begin
      count_sat = CW'(num_categories);
    end
  end

  assign bp_wr.low_point  = req.low_point;
  assign bp_wr.mid_point  = req.mid_point;
  assign bp_wr.high_point = req.high_point;
  assign bp               = bp_t'(bp_rdata);

  tfz_ram #(
    .WIDTH ($bits(bp_t)),
    .DEPTH (MAX_CATEGORIES)
  ) u_bp_ram (
    .clk   (clk),
    .we    (bp_we),
    .waddr (AW'(req.cat_index)),
    .wdata (bp_wr),
    .re    (bp_re),
    .raddr (idx),
    .rdata (bp_rdata)
  );

  tfz_ram #(
    .WIDTH (PCT_W),
    .DEPTH (MAX_CATEGORIES)
  ) u_pct_ram (
    .clk   (clk),
    .we    (pct_we),
    .waddr (idx),
    .wdata (pct_val),
    .re    (pct_re),
    .raddr (idx),
    .rdata (pct_rdata)
  );

  tfz_div #(
    .DW (TW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_init),
    .num_bits (div_bits),
    .den      (div_den),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign xs   = {sample_r[15], sample_r};
  assign lo   = {bp.low_point[15], bp.low_point};
  assign mi   = {bp.mid_point[15], bp.mid_point};
  assign hi   = {bp.high_point[15], bp.high_point};
  assign d_xl = xs - lo;
  assign d_ml = mi - lo;
  assign d_hx = hi - xs;
  assign d_hm = hi - mi;

  always_comb begin
    if (xs <= lo || xs >= hi) begin
      ramp = RAMP_ZERO;
    end else if (xs > mi) begin
      ramp = RAMP_FALL;
    end else if (xs == mi) begin
      ramp = RAMP_PEAK;
    end else begin
      ramp = RAMP_RISE;
    end
  end

  assign pct_val = PCT_W'(share) * PCT_W'(PERCENT);
  assign whole   = total[TW-1:FRAC_W];
  assign run_sum = run + TW'(pct_rdata);
  assign hit     = !found && (run_sum >= limit);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_fz) begin
          state_next = (count_sat == '0) ? ST_ZERO : ST_P1_RD;
        end
      end
      ST_P1_RD: state_next = ST_P1_EVAL;
      ST_P1_EVAL: begin
        if (ramp == RAMP_RISE || ramp == RAMP_FALL) begin
          state_next = ST_P1_DIV;
        end else begin
          state_next = ST_P1_ACC;
        end
      end
      ST_P1_DIV: begin
        if (div_done) begin
          state_next = ST_P1_ACC;
        end
      end
      ST_P1_ACC: state_next = last_idx ? ST_CHECK : ST_P1_RD;
      ST_CHECK: begin
        if (total == '0) begin
          state_next = ST_ZERO;
        end else if (whole == '0) begin
          state_next = ST_P2_RD;
        end else begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_done) begin
          state_next = ST_P2_RD;
        end
      end
      ST_P2_RD: state_next = ST_P2_EVAL;
      ST_P2_EVAL: begin
        state_next = (TW'(pct_rdata) == total) ? ST_EMIT : ST_P2_DIV;
      end
      ST_P2_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: state_next = last_idx ? ST_IDLE : ST_P2_RD;
      ST_ZERO: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != ST_IDLE);
    cfg_ready    = (state == ST_IDLE);
    bp_we        = accept_load && load_ok;
    bp_re        = (state == ST_P1_RD);
    pct_we       = (state == ST_P1_ACC);
    pct_re       = (state == ST_P2_RD);
    div_start    = 1'b0;
    div_init     = '0;
    div_bits     = '0;
    div_den      = '0;
    result_valid = 1'b0;
    result       = '0;
    case (state)
      ST_P1_EVAL: begin
        if (ramp == RAMP_RISE) begin
          div_start = 1'b1;
          div_init  = TW'(d_xl[15:0]);
          div_den   = TW'(d_ml[15:0]);
        end else if (ramp == RAMP_FALL) begin
          div_start = 1'b1;
          div_init  = TW'(d_hx[15:0]);
          div_den   = TW'(d_hm[15:0]);
        end
      end
      ST_CHECK: begin
        div_start = (total != '0) && (whole != '0);
        div_bits  = rand_r;
        div_den   = TW'(whole);
      end
      ST_P2_EVAL: begin
        div_start = (TW'(pct_rdata) != total);
        div_init  = TW'(pct_rdata);
        div_den   = total;
      end
      ST_EMIT: begin
        result_valid        = 1'b1;
        result.category     = CAT_W'(idx);
        result.membership   = memb;
        result.chosen       = chosen_r;
        result.out_of_range = 1'b0;
        result.last         = last_idx;
      end
      ST_ZERO: begin
        result_valid        = 1'b1;
        result.out_of_range = 1'b1;
        result.last         = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      num_categories <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        num_categories <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept_fz) begin
          sample_r <= req.sample;
          rand_r   <= req.rand_word;
          count_r  <= count_sat;
          idx      <= '0;
          total    <= '0;
        end
      end
      ST_P1_EVAL: begin
        if (ramp == RAMP_ZERO) begin
          share <= '0;
        end else if (ramp == RAMP_PEAK) begin
          share <= ONE_Q16;
        end
      end
      ST_P1_DIV: begin
        if (div_done) begin
          share <= {1'b0, div_quo};
        end
      end
      ST_P1_ACC: begin
        total <= total + TW'(pct_val);
        if (!last_idx) begin
          idx <= idx + AW'(1);
        end
      end
      ST_CHECK: begin
        limit <= '0;
        idx   <= '0;
        run   <= '0;
        found <= 1'b0;
      end
      ST_MOD: begin
        if (div_done) begin
          limit <= {div_rem[WW-1:0], {FRAC_W{1'b0}}};
        end
      end
      ST_P2_EVAL: begin
        run      <= run_sum;
        chosen_r <= hit;
        found    <= found || hit;
        if (TW'(pct_rdata) == total) begin
          memb <= ONE_Q16;
        end
      end
      ST_P2_DIV: begin
        if (div_done) begin
          memb <= {1'b0, div_quo};
        end
      end
      ST_EMIT: begin
        if (!last_idx) begin
          idx <= idx + AW'(1);
        end
      end
      default: ;
    endcase
  end

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe outside a transaction");

  a_oor_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.out_of_range) |-> result.last)
    else $error("out-of-range result not marked last");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !busy)
    else $error("busy after final result");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_P1_DIV || state == ST_MOD || state == ST_P2_DIV))
    else $error("divider finished outside a wait state");

endmodule

`default_nettype wire
